// ===== rtl/gic_pkg.sv =====
// Shared types and constants for the gamepad input conditioner.
// Command/status structs between controller and datapath, button masks.
// No dependencies.
`default_nettype none

package gic_pkg;

   // axis and trigger widths
   localparam int AXIS_W   = 16;
   localparam int TRIG_W   = 8;
   localparam int BTN_W    = 14;
   localparam int DZ_W     = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 15;

   // iterations for root and quotient
   localparam int STEP_CNT = 16;
   localparam int STEP_W   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DZ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DZ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_TH  = 2'd2;

   // reset values
   localparam logic [DZ_W-1:0]   LEFT_DZ_RST  = 15'd7849;
   localparam logic [DZ_W-1:0]   RIGHT_DZ_RST = 15'd8689;
   localparam logic [TRIG_W-1:0] TRIG_TH_RST  = 8'd30;
   localparam logic [DZ_W-1:0]   FULL_SCALE   = 15'h7fff;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_SQ     = 4'd2;
   localparam logic [3:0] OP_SUM    = 4'd3;
   localparam logic [3:0] OP_ROOT   = 4'd4;
   localparam logic [3:0] OP_ZERO   = 4'd5;
   localparam logic [3:0] OP_DEN    = 4'd6;
   localparam logic [3:0] OP_NUM    = 4'd7;
   localparam logic [3:0] OP_DIVI   = 4'd8;
   localparam logic [3:0] OP_DIV    = 4'd9;
   localparam logic [3:0] OP_STORE  = 4'd10;
   localparam logic [3:0] OP_COMMIT = 4'd11;

   typedef struct packed {
      logic [3:0] op;
      logic       stick;   // 0 left, 1 right
      logic       axis;    // 0 x, 1 y
   } cmd_type;

   typedef struct packed {
      logic conn;   // latched report is connected
      logic skip;   // stick inside deadzone
   } status_type;

   // button masks, in output bit order
   localparam logic [15:0] BTN_MASK [16] = '{
      16'h0001, 16'h0002, 16'h0004, 16'h0008,
      16'h8000, 16'h1000, 16'h4000, 16'h2000,
      16'h0100, 16'h0200, 16'h0040, 16'h0080,
      16'h0010, 16'h0020, 16'h0400, 16'h0800
   };

endpackage

`default_nettype wire

// ===== rtl/gic_ctrl.sv =====
// Sequencer for the gamepad input conditioner.
// Steps the datapath through root, rescale and commit. Uses gic_pkg.
`default_nettype none

module gic_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output gic_pkg::cmd_type    cmd,
   input  gic_pkg::status_type status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_ROOT  = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_ZERO  = 4'd6;
   localparam logic [3:0] S_DEN   = 4'd7;
   localparam logic [3:0] S_NUM   = 4'd8;
   localparam logic [3:0] S_DIVI  = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_STORE = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   localparam logic [gic_pkg::STEP_W-1:0] LAST_STEP = gic_pkg::STEP_W'(gic_pkg::STEP_CNT - 1);

   logic [3:0]                  state_ff, state_in;
   logic [gic_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                        stick_ff, stick_in;
   logic                        axis_ff, axis_in;
   logic                        valid_ff, valid_in;

   assign rsp_tvalid = valid_ff;

   // next state and command
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      stick_in   = stick_ff;
      axis_in    = axis_ff;
      valid_in   = valid_ff & ~rsp_tready;
      req_tready = 1'b0;
      cmd.op     = gic_pkg::OP_NONE;
      cmd.stick  = stick_ff;
      cmd.axis   = axis_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = gic_pkg::OP_LOAD;
               stick_in = 1'b0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = status.conn ? S_SQ : S_FIN;
         end
         S_SQ: begin
            cmd.op   = gic_pkg::OP_SQ;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = gic_pkg::OP_SUM;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.op = gic_pkg::OP_ROOT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) state_in = S_CHK;
         end
         S_CHK: begin
            state_in = status.skip ? S_ZERO : S_DEN;
         end
         S_ZERO: begin
            cmd.op   = gic_pkg::OP_ZERO;
            stick_in = 1'b1;
            state_in = stick_ff ? S_FIN : S_SQ;
         end
         S_DEN: begin
            cmd.op   = gic_pkg::OP_DEN;
            axis_in  = 1'b0;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.op   = gic_pkg::OP_NUM;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.op   = gic_pkg::OP_DIVI;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = gic_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) state_in = S_STORE;
         end
         S_STORE: begin
            cmd.op  = gic_pkg::OP_STORE;
            axis_in = 1'b1;
            if (!axis_ff) begin
               state_in = S_NUM;
            end else begin
               stick_in = 1'b1;
               state_in = stick_ff ? S_FIN : S_SQ;
            end
         end
         S_FIN: begin
            // wait for the output register to free up
            if (!valid_ff || rsp_tready) begin
               cmd.op   = gic_pkg::OP_COMMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         stick_ff <= 1'b0;
         axis_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stick_ff <= stick_in;
         axis_ff  <= axis_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gic_dp.sv =====
// Datapath for the gamepad input conditioner: config registers, bit-serial
// square root, shared restoring divider, buttons and held state. Uses gic_pkg.
`default_nettype none

module gic_dp #(
   parameter int BUTTON_COUNT = 14
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  gic_pkg::cmd_type                    cmd,
   output gic_pkg::status_type                 status,
   // input item
   input  wire                                 in_conn,
   input  wire  [4*gic_pkg::AXIS_W-1:0]        in_axes,
   input  wire  [gic_pkg::TRIG_W-1:0]          in_lt,
   input  wire  [gic_pkg::TRIG_W-1:0]          in_rt,
   input  wire  [15:0]                         in_btn,
   // config writes
   input  wire                                 csr_we,
   input  wire  [gic_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [gic_pkg::CSR_DAT_W-1:0]       csr_data,
   // held result
   output logic                                out_conn,
   output logic [4*gic_pkg::AXIS_W-1:0]        out_axes,
   output logic [gic_pkg::TRIG_W-1:0]          out_lt,
   output logic [gic_pkg::TRIG_W-1:0]          out_rt,
   output logic [gic_pkg::BTN_W-1:0]           out_pressed,
   output logic [gic_pkg::BTN_W-1:0]           out_changed
);

   localparam int AW = gic_pkg::AXIS_W;

   // config registers
   logic [gic_pkg::DZ_W-1:0]   ldz_ff, rdz_ff;
   logic [gic_pkg::TRIG_W-1:0] th_ff;

   // latched item
   logic                   conn_ff;
   logic [AW-1:0]          raw_ff [4];
   logic [gic_pkg::TRIG_W-1:0] lt_ff, rt_ff;
   logic [15:0]            btn_ff;

   // working registers
   logic [31:0]  sqx_ff, sqy_ff;
   logic [31:0]  v_ff, root_ff, bit_ff;
   logic [30:0]  den_ff, prod_ff, rem_ff;
   logic [15:0]  numlo_ff, q_ff;
   logic [AW-1:0] res_ff [4];

   // held state
   logic                       hconn_ff;
   logic [AW-1:0]              hax_ff [4];
   logic [gic_pkg::TRIG_W-1:0] hlt_ff, hrt_ff;
   logic [gic_pkg::BTN_W-1:0]  prev_ff, chg_ff;

   // operand selection
   logic [AW-1:0]           rx, ry, ra, ax, ay, aa;
   logic [gic_pkg::DZ_W-1:0] dz, dz_range, clipped, diff;
   logic [15:0]             m;
   logic [31:0]             trial;
   logic [31:0]             dtrial;
   logic [14:0]             qsat;
   logic [AW-1:0]           qsigned;
   logic [gic_pkg::BTN_W-1:0] pressed;

   function automatic logic [15:0] mag16(input logic [15:0] r);
      return r[15] ? (~r + 16'd1) : r;
   endfunction

   assign rx       = raw_ff[{cmd.stick, 1'b0}];
   assign ry       = raw_ff[{cmd.stick, 1'b1}];
   assign ra       = raw_ff[{cmd.stick, cmd.axis}];
   assign ax       = mag16(rx);
   assign ay       = mag16(ry);
   assign aa       = mag16(ra);
   assign dz       = cmd.stick ? rdz_ff : ldz_ff;
   assign dz_range = gic_pkg::FULL_SCALE - dz;
   assign m        = root_ff[15:0];
   assign clipped  = m[15] ? gic_pkg::FULL_SCALE : m[14:0];
   assign diff     = clipped - dz;
   assign trial    = root_ff + bit_ff;
   assign dtrial   = {rem_ff, numlo_ff[15]};
   assign qsat     = q_ff[15] ? 15'h7fff : q_ff[14:0];
   assign qsigned  = ra[15] ? (~{1'b0, qsat} + 16'd1) : {1'b0, qsat};

   assign status.conn = conn_ff;
   assign status.skip = (dz == gic_pkg::FULL_SCALE) || (m <= {1'b0, dz});

   // button decode; bits past BUTTON_COUNT stay clear
   always_comb begin
      for (int i = 0; i < gic_pkg::BTN_W; i++) begin
         pressed[i] = (i < BUTTON_COUNT) &&
                      ((btn_ff & gic_pkg::BTN_MASK[i]) == gic_pkg::BTN_MASK[i]);
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ldz_ff <= gic_pkg::LEFT_DZ_RST;
         rdz_ff <= gic_pkg::RIGHT_DZ_RST;
         th_ff  <= gic_pkg::TRIG_TH_RST;
      end else if (csr_we) begin
         case (csr_index)
            gic_pkg::CSR_LEFT_DZ:  ldz_ff <= csr_data;
            gic_pkg::CSR_RIGHT_DZ: rdz_ff <= csr_data;
            gic_pkg::CSR_TRIG_TH:  th_ff  <= csr_data[gic_pkg::TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   // arithmetic steps
   always_ff @(posedge clock) begin
      case (cmd.op)
         gic_pkg::OP_LOAD: begin
            conn_ff <= in_conn;
            for (int i = 0; i < 4; i++) raw_ff[i] <= in_axes[i*AW +: AW];
            lt_ff  <= in_lt;
            rt_ff  <= in_rt;
            btn_ff <= in_btn;
         end
         gic_pkg::OP_SQ: begin
            sqx_ff <= 32'(ax) * 32'(ax);
            sqy_ff <= 32'(ay) * 32'(ay);
         end
         gic_pkg::OP_SUM: begin
            v_ff    <= sqx_ff + sqy_ff;
            root_ff <= '0;
            bit_ff  <= 32'h4000_0000;
         end
         gic_pkg::OP_ROOT: begin
            // one result bit per step
            if (v_ff >= trial) begin
               v_ff    <= v_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         gic_pkg::OP_ZERO: begin
            res_ff[{cmd.stick, 1'b0}] <= '0;
            res_ff[{cmd.stick, 1'b1}] <= '0;
         end
         gic_pkg::OP_DEN: begin
            den_ff <= 31'(m) * 31'(dz_range);
         end
         gic_pkg::OP_NUM: begin
            prod_ff <= 31'(aa) * 31'(diff);
         end
         gic_pkg::OP_DIVI: begin
            // numerator is prod * 2^15; top 30 bits start the remainder
            rem_ff   <= {1'b0, prod_ff[30:1]};
            numlo_ff <= {prod_ff[0], 15'd0};
            q_ff     <= '0;
         end
         gic_pkg::OP_DIV: begin
            if (dtrial >= {1'b0, den_ff}) begin
               rem_ff <= 31'(dtrial - {1'b0, den_ff});
               q_ff   <= {q_ff[14:0], 1'b1};
            end else begin
               rem_ff <= dtrial[30:0];
               q_ff   <= {q_ff[14:0], 1'b0};
            end
            numlo_ff <= {numlo_ff[14:0], 1'b0};
         end
         gic_pkg::OP_STORE: begin
            res_ff[{cmd.stick, cmd.axis}] <= qsigned;
         end
         default: ;
      endcase
   end

   // held state, which is also the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hconn_ff <= 1'b0;
         for (int i = 0; i < 4; i++) hax_ff[i] <= '0;
         hlt_ff  <= '0;
         hrt_ff  <= '0;
         prev_ff <= '0;
         chg_ff  <= '0;
      end else if (cmd.op == gic_pkg::OP_COMMIT) begin
         hconn_ff <= conn_ff;
         if (conn_ff) begin
            for (int i = 0; i < 4; i++) hax_ff[i] <= res_ff[i];
            hlt_ff  <= (lt_ff < th_ff) ? '0 : lt_ff;
            hrt_ff  <= (rt_ff < th_ff) ? '0 : rt_ff;
            prev_ff <= pressed;
            chg_ff  <= pressed ^ prev_ff;
         end
      end
   end

   assign out_conn    = hconn_ff;
   assign out_axes    = {hax_ff[3], hax_ff[2], hax_ff[1], hax_ff[0]};
   assign out_lt      = hlt_ff;
   assign out_rt      = hrt_ff;
   assign out_pressed = prev_ff;
   assign out_changed = chg_ff;

endmodule

`default_nettype wire

// ===== rtl/gamepad_input_conditioner.sv =====
// Top level of the gamepad input conditioner.
// Instantiates gic_ctrl and gic_dp; uses gic_pkg.
//
//   channel | ports  | direction | content
//   request | req_*  | in        | one gamepad report
//   result  | rsp_*  | out       | one conditioned report
//   config  | csr_*  | in        | register writes, always ready
//
// For a connected report each stick runs a bit-serial square root, then
// two 16-step quotients from the shared divider unless the stick is in
// its deadzone. A disconnected report goes straight to the commit. One
// report is in work at a time; a finished result waits in the output
// register while the next is taken.
// Synchronous reset restores the registers and clears the held state.
`default_nettype none

module gamepad_input_conditioner #(
   parameter int BUTTON_COUNT = 14
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [95:0]  req_tdata,  // left_raw_x, left_raw_y, right_raw_x, right_raw_y,
                                    // left_trigger_raw, right_trigger_raw, button_word
   input  wire  [0:0]   req_tuser,  // connected
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [111:0] rsp_tdata,  // left_x, left_y, right_x, right_y, left_trigger,
                                    // right_trigger, pressed_buttons, changed_buttons, 0 pad
   output logic [0:0]   rsp_tuser,  // is_connected
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [1:0]   csr_index,
   input  wire  [14:0]  csr_data
);

   gic_pkg::cmd_type    cmd;
   gic_pkg::status_type status;

   logic [63:0] out_axes;
   logic [7:0]  out_lt, out_rt;
   logic [13:0] out_pressed, out_changed;
   logic        out_conn;

   assign csr_ready = 1'b1;

   gic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gic_dp #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_conn     (req_tuser[0]),
      .in_axes     (req_tdata[63:0]),
      .in_lt       (req_tdata[71:64]),
      .in_rt       (req_tdata[79:72]),
      .in_btn      (req_tdata[95:80]),
      .csr_we      (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .out_conn    (out_conn),
      .out_axes    (out_axes),
      .out_lt      (out_lt),
      .out_rt      (out_rt),
      .out_pressed (out_pressed),
      .out_changed (out_changed)
   );

   assign rsp_tdata = {4'd0, out_changed, out_pressed, out_rt, out_lt, out_axes};
   assign rsp_tuser = out_conn;

endmodule

`default_nettype wire

// ===== rtl/gic_check.sv =====
// Port-level checks for the gamepad input conditioner, bound to the top.
// No package dependency.
`default_nettype none

module gic_check (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [111:0] rsp_tdata
);

   // a stalled result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing is presented right after reset
   a_rst_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // one report at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second report taken while busy");

   // saturation never yields the most negative code
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] != 16'h8000 && rsp_tdata[31:16] != 16'h8000 &&
                     rsp_tdata[47:32] != 16'h8000 && rsp_tdata[63:48] != 16'h8000)
      else $error("axis result out of range");

endmodule

bind gamepad_input_conditioner gic_check u_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== test/gamepad_input_conditioner_test.sv =====
// Self-checking bench for gamepad_input_conditioner: random and directed reports,
// register writes between phases, results checked against a built-in predictor.
// Depends on gic_pkg and the gamepad_input_conditioner RTL.
`timescale 1ns / 100ps

module gamepad_input_conditioner_test;

   typedef struct packed {
      logic              conn;
      logic [15:0]       lx, ly, rx, ry;
      logic [7:0]        lt, rt;
      logic [15:0]       buttons;
   } report_type;

   typedef struct packed {
      logic              conn;
      logic [15:0]       lx, ly, rx, ry;
      logic [7:0]        lt, rt;
      logic [13:0]       pressed, changed;
   } pad_state_type;

   // register index with no register behind it
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [111:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [14:0]  csr_data = '0;

   gamepad_input_conditioner uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [14:0]   left_dz, right_dz;
   logic [7:0]    trig_th;
   logic [63:0]   held_sticks;
   logic [15:0]   held_trigs;
   logic [13:0]   prev_pressed, held_changes;

   report_type    pending_reports[$];
   pad_state_type expected_pads[$];
   bit            failed = 0;
   bit            quiet = 0;       // no idling stretch
   int            idle_cycles = 0;

   function automatic logic [31:0] floor_sqrt(logic [31:0] v);
      logic [31:0] root, bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] axis_mag(logic [15:0] a);
      return a[15] ? 32'h10000 - a : {16'd0, a};
   endfunction

   function automatic logic [15:0] rescale_axis(logic [15:0] a, logic [31:0] m,
                                                logic [31:0] dz);
      logic [31:0] clipped;
      logic [63:0] num, den, q;
      clipped = (m > 32767) ? 32767 : m;
      num = 64'(axis_mag(a)) * 64'(clipped - dz) * 64'd32768;
      den = 64'(m) * 64'(32767 - dz);
      q = num / den;
      if (q > 32767) q = 32767;
      return a[15] ? 16'(-q) : q[15:0];
   endfunction

   task automatic condition_stick(input logic [15:0] x, y, input logic [14:0] dz,
                                  output logic [15:0] ox, oy);
      logic [31:0] ax, ay, m;
      ax = axis_mag(x);
      ay = axis_mag(y);
      m = floor_sqrt(ax * ax + ay * ay);
      if (dz >= 32767 || m <= dz) begin
         ox = '0;
         oy = '0;
      end else begin
         ox = rescale_axis(x, m, dz);
         oy = rescale_axis(y, m, dz);
      end
   endtask

   task automatic predict_report(input report_type r);
      pad_state_type p;
      logic [15:0] lx, ly, rx, ry;
      logic [7:0]  lt, rt;
      logic [13:0] pr;
      if (r.conn) begin
         condition_stick(r.lx, r.ly, left_dz, lx, ly);
         condition_stick(r.rx, r.ry, right_dz, rx, ry);
         lt = (r.lt < trig_th) ? 8'd0 : r.lt;
         rt = (r.rt < trig_th) ? 8'd0 : r.rt;
         pr = '0;
         for (int i = 0; i < gic_pkg::BTN_W; i++)
            pr[i] = (r.buttons & gic_pkg::BTN_MASK[i]) == gic_pkg::BTN_MASK[i];
         held_changes = pr ^ prev_pressed;
         prev_pressed = pr;
         held_sticks = {ry, rx, ly, lx};
         held_trigs = {rt, lt};
      end
      p.conn = r.conn;
      {p.ry, p.rx, p.ly, p.lx} = held_sticks;
      {p.rt, p.lt} = held_trigs;
      p.pressed = prev_pressed;
      p.changed = held_changes;
      expected_pads.push_back(p);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_reports.size() != 0 && (quiet || $urandom_range(99) >= 19)) begin
               report_type r;
               r = pending_reports.pop_front();
               predict_report(r);
               req_tvalid <= 1;
               req_tuser <= r.conn;
               req_tdata <= {r.buttons, r.rt, r.lt, r.ry, r.rx, r.ly, r.lx};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            pad_state_type got, want;
            got.conn = rsp_tuser[0];
            {got.changed, got.pressed, got.rt, got.lt, got.ry, got.rx, got.ly, got.lx}
               = rsp_tdata[107:0];
            if (expected_pads.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               failed = 1;
            end else begin
               want = expected_pads.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  failed = 1;
               end
            end
         end
         rsp_tready <= quiet || $urandom_range(99) >= 19;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic report_type random_report(bit conn_bias);
      report_type r;
      r.conn = conn_bias ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
      case ($urandom_range(3))
         0: {r.lx, r.ly, r.rx, r.ry} = {$urandom, $urandom};
         1: begin   // near or inside the deadzone
            r.lx = 16'($signed($urandom_range(20000)) - 10000);
            r.ly = 16'($signed($urandom_range(20000)) - 10000);
            r.rx = 16'($signed($urandom_range(20000)) - 10000);
            r.ry = 16'($signed($urandom_range(20000)) - 10000);
         end
         2: begin   // full-scale corners
            r.lx = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            r.ly = $urandom_range(1) ? 16'h8000 : 16'($urandom);
            r.rx = 16'($urandom);
            r.ry = $urandom_range(1) ? 16'h8001 : 16'h7fff;
         end
         default: begin
            r.lx = 16'($urandom);
            r.ly = '0;
            r.rx = '0;
            r.ry = 16'($urandom);
         end
      endcase
      r.lt = 8'($urandom);
      r.rt = 8'($urandom);
      r.buttons = 16'($urandom);
      return r;
   endfunction

   // one register transfer; the caller drops csr_valid after the last one
   task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gic_pkg::CSR_LEFT_DZ:  left_dz = val;
         gic_pkg::CSR_RIGHT_DZ: right_dz = val;
         gic_pkg::CSR_TRIG_TH:  trig_th = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_reports.size() != 0 || expected_pads.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   initial begin
      report_type r;
      left_dz = gic_pkg::LEFT_DZ_RST;
      right_dz = gic_pkg::RIGHT_DZ_RST;
      trig_th = gic_pkg::TRIG_TH_RST;
      held_sticks = '0;
      held_trigs = '0;
      prev_pressed = '0;
      held_changes = '0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: disconnected first, extremes, every button, thresholds
      r = '0;
      pending_reports.push_back(r);
      r = '{1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 8'hff, 8'hff, 16'hffff};
      pending_reports.push_back(r);
      r = '{1, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 8'd29, 8'd30, 16'h0000};
      pending_reports.push_back(r);
      r = '{0, 16'h1234, 16'h5678, 16'h1111, 16'h2222, 8'd1, 8'd2, 16'h00ff};
      pending_reports.push_back(r);
      r = '{1, 16'd7849, 16'd0, 16'd8689, 16'd0, 8'd0, 8'd31, 16'h0f0f};
      pending_reports.push_back(r);
      r = '{1, 16'd7850, 16'd0, 16'd8690, 16'd0, 8'd0, 8'd31, 16'hf0f0};
      pending_reports.push_back(r);
      for (int i = 0; i < 16; i++) begin
         r = '{1, 16'h7fff, 16'h8001, 16'hc000, 16'h4000, 8'd128, 8'd0, 16'(1 << i)};
         pending_reports.push_back(r);
      end
      drain();

      // phases over register settings; last phase restores reset values
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(gic_pkg::CSR_LEFT_DZ, 15'd0);
               write_reg(gic_pkg::CSR_RIGHT_DZ, 15'd0);
               write_reg(gic_pkg::CSR_TRIG_TH, 15'd0); end
            1: begin write_reg(gic_pkg::CSR_LEFT_DZ, 15'd32766);
               write_reg(gic_pkg::CSR_RIGHT_DZ, 15'h7fff);
               write_reg(gic_pkg::CSR_TRIG_TH, 15'd255); end
            2: begin write_reg(gic_pkg::CSR_LEFT_DZ, 15'($urandom));
               write_reg(gic_pkg::CSR_RIGHT_DZ, 15'($urandom));
               write_reg(gic_pkg::CSR_TRIG_TH, 15'($urandom));
               write_reg(CSR_SPARE, 15'($urandom)); end
            3: begin write_reg(gic_pkg::CSR_LEFT_DZ, 15'h7fff);
               write_reg(gic_pkg::CSR_RIGHT_DZ, 15'd32766);
               write_reg(gic_pkg::CSR_TRIG_TH, 15'd1); end
            4: begin write_reg(gic_pkg::CSR_LEFT_DZ, 15'h5555);
               write_reg(gic_pkg::CSR_RIGHT_DZ, 15'h2aaa);
               write_reg(gic_pkg::CSR_TRIG_TH, 15'h00aa); end
            default: begin write_reg(gic_pkg::CSR_LEFT_DZ, gic_pkg::LEFT_DZ_RST);
               write_reg(gic_pkg::CSR_RIGHT_DZ, gic_pkg::RIGHT_DZ_RST);
               write_reg(gic_pkg::CSR_TRIG_TH, 15'(gic_pkg::TRIG_TH_RST)); end
         endcase
         csr_valid <= 0;
         quiet = (ph == 4);
         for (int i = 0; i < 100; i++)
            pending_reports.push_back(random_report(ph != 2));
         drain();
      end
      quiet = 0;

      if (!failed) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/gic_pkg.sv
rtl/gic_ctrl.sv
rtl/gic_dp.sv
rtl/gamepad_input_conditioner.sv
rtl/gic_check.sv
test/gamepad_input_conditioner_test.sv
